FILE: rtl/tptl_pkg.sv
package tptl_pkg;

  localparam int PAGE_SLOTS_DEF  = 64;
  localparam int PAGE_TOKENS_DEF = 16;
  localparam int MAX_HOT_RST     = 16;
  localparam int MAX_RES         = 64;

  typedef enum logic [2:0] {
    MODE_ALLOC   = 3'd0,
    MODE_FREE    = 3'd1,
    MODE_ACCESS  = 3'd2,
    MODE_WRITE   = 3'd3,
    MODE_PROMOTE = 3'd4,
    MODE_WARM    = 3'd5,
    MODE_COLD    = 3'd6,
    MODE_CLEAR   = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    TIER_FREE = 2'd0,
    TIER_HOT  = 2'd1,
    TIER_WARM = 2'd2,
    TIER_COLD = 2'd3
  } tier_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_PAGE = 2'd1,
    ST_FULL    = 2'd2,
    ST_NO_HOT  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_PROMO,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic        valid;
    tier_e       tier;
    logic        dirty;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic   wr;
    logic   clr;
    entry_t ent;
  } cell_cmd_t;

  typedef struct packed {
    logic        free_found;
    logic        hot_found;
    logic        hot_dirty;
    logic [31:0] hot_stamp;
  } token_t;

  typedef struct packed {
    logic [5:0]  page_id;
    status_e     status;
    tier_e       tier;
    logic [15:0] span_lo;
    logic [15:0] span_hi;
    logic        hit;
    logic        fault;
    logic        load_request;
    logic        save_request;
    logic        evicted_valid;
    logic [5:0]  evicted_page;
    logic        last;
  } res_t;

endpackage

FILE: rtl/tiered_page_table_lru.sv
// A request that needs a scan passes a token down the cell chain, one cell per cycle.
// Allocation scans the chain once per page; a request that raises a page into a full hot
// tier scans it to find the least recently used hot page. A new request is accepted only
// in the idle state, after the previous result has gone to the output register.
// Reset (rst_ni low, asynchronous): every slot invalid, counters zero, hot budget 16.
module tiered_page_table_lru import tptl_pkg::*; #(
  parameter int PAGE_SLOTS  = PAGE_SLOTS_DEF,
  parameter int PAGE_TOKENS = PAGE_TOKENS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // page_index[5:0], token_count[21:6], zero fill
  input  logic [2:0]  s_axis_tuser,  // mode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // page_id[5:0], status[7:6], tier[9:8], span_lo[25:10], span_hi[41:26],
  // hit[42], fault[43], load_request[44], save_request[45], evicted_valid[46],
  // evicted_page[52:47], zero fill
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i
);

  localparam int AW = $clog2(PAGE_SLOTS);

  cell_cmd_t     cmd;
  logic [AW-1:0] wr_idx;
  entry_t        ent [PAGE_SLOTS];
  token_t        tok_in [PAGE_SLOTS];
  token_t        tok_out [PAGE_SLOTS];
  logic [AW-1:0] free_in [PAGE_SLOTS];
  logic [AW-1:0] free_out [PAGE_SLOTS];
  logic [AW-1:0] hot_in [PAGE_SLOTS];
  logic [AW-1:0] hot_out [PAGE_SLOTS];
  res_t          res;

  for (genvar k = 0; k < PAGE_SLOTS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign tok_in[k]  = '0;
      assign free_in[k] = '0;
      assign hot_in[k]  = '0;
    end else begin : g_link
      assign tok_in[k]  = tok_out[k-1];
      assign free_in[k] = free_out[k-1];
      assign hot_in[k]  = hot_out[k-1];
    end

    tptl_cell #(
      .AW       (AW),
      .CELL_IDX (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .wr_idx_i   (wr_idx),
      .tok_i      (tok_in[k]),
      .free_idx_i (free_in[k]),
      .hot_idx_i  (hot_in[k]),
      .ent_o      (ent[k]),
      .tok_o      (tok_out[k]),
      .free_idx_o (free_out[k]),
      .hot_idx_o  (hot_out[k])
    );
  end

  tptl_ctrl #(
    .PAGE_SLOTS  (PAGE_SLOTS),
    .PAGE_TOKENS (PAGE_TOKENS),
    .AW          (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .mode_i        (s_axis_tuser),
    .page_index_i  (s_axis_tdata[5:0]),
    .token_count_i (s_axis_tdata[21:6]),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .ent_i         (ent),
    .tok_i         (tok_out[PAGE_SLOTS-1]),
    .free_idx_i    (free_out[PAGE_SLOTS-1]),
    .hot_idx_i     (hot_out[PAGE_SLOTS-1]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_o         (res),
    .cmd_o         (cmd),
    .wr_idx_o      (wr_idx)
  );

  assign m_axis_tdata = {3'b000, res.evicted_page, res.evicted_valid, res.save_request,
                         res.load_request, res.fault, res.hit, res.span_hi,
                         res.span_lo, res.tier, res.status, res.page_id};
  assign m_axis_tlast = res.last;

endmodule

FILE: rtl/tptl_cell.sv
module tptl_cell import tptl_pkg::*; #(
  parameter int AW       = 6,
  parameter int CELL_IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_cmd_t     cmd_i,
  input  logic [AW-1:0] wr_idx_i,
  input  token_t        tok_i,
  input  logic [AW-1:0] free_idx_i,
  input  logic [AW-1:0] hot_idx_i,
  output entry_t        ent_o,
  output token_t        tok_o,
  output logic [AW-1:0] free_idx_o,
  output logic [AW-1:0] hot_idx_o
);

  entry_t        ent_q;
  token_t        tok_d, tok_q;
  logic [AW-1:0] free_idx_d, free_idx_q, hot_idx_d, hot_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else if (cmd_i.clr) begin
      ent_q <= '0;
    end else if (cmd_i.wr && (wr_idx_i == AW'(CELL_IDX))) begin
      ent_q <= cmd_i.ent;
    end
  end

  always_comb begin
    tok_d      = tok_i;
    free_idx_d = free_idx_i;
    hot_idx_d  = hot_idx_i;
    if (!tok_i.free_found && !ent_q.valid) begin
      tok_d.free_found = 1'b1;
      free_idx_d       = AW'(CELL_IDX);
    end
    if (ent_q.valid && (ent_q.tier == TIER_HOT) &&
        (!tok_i.hot_found || (ent_q.stamp < tok_i.hot_stamp))) begin
      tok_d.hot_found = 1'b1;
      tok_d.hot_dirty = ent_q.dirty;
      tok_d.hot_stamp = ent_q.stamp;
      hot_idx_d       = AW'(CELL_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    free_idx_q <= free_idx_d;
    hot_idx_q  <= hot_idx_d;
  end

  assign ent_o      = ent_q;
  assign tok_o      = tok_q;
  assign free_idx_o = free_idx_q;
  assign hot_idx_o  = hot_idx_q;

endmodule

FILE: rtl/tptl_ctrl.sv
module tptl_ctrl import tptl_pkg::*; #(
  parameter int PAGE_SLOTS  = PAGE_SLOTS_DEF,
  parameter int PAGE_TOKENS = PAGE_TOKENS_DEF,
  parameter int AW          = $clog2(PAGE_SLOTS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    mode_i,
  input  logic [5:0]    page_index_i,
  input  logic [15:0]   token_count_i,
  input  logic          cfg_we_i,
  input  logic [6:0]    cfg_wdata_i,
  input  entry_t        ent_i [PAGE_SLOTS],
  input  token_t        tok_i,
  input  logic [AW-1:0] free_idx_i,
  input  logic [AW-1:0] hot_idx_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output res_t          out_o,
  output cell_cmd_t     cmd_o,
  output logic [AW-1:0] wr_idx_o
);

  localparam int CW = $clog2(PAGE_SLOTS + 1);

  state_e        state_d, state_q;
  mode_e         mode_d, mode_q;
  logic [5:0]    idx_d, idx_q;
  logic [15:0]   tc_d, tc_q, start_d, start_q;
  logic [5:0]    k_d, k_q;
  logic [CW-1:0] scan_cnt_d, scan_cnt_q;
  logic [6:0]    hot_count_d, hot_count_q, max_hot_d, max_hot_q;
  logic [31:0]   use_clock_d, use_clock_q;
  res_t          res_d, res_q, out_d, out_q;
  logic          out_valid_d, out_valid_q;

  logic          in_range, hot_full, more, out_free, scan_done, needs_hot;
  logic [AW-1:0] rd_idx;
  entry_t        e;
  logic [16:0]   span_end;
  logic [15:0]   end_tok;

  assign in_range  = {26'd0, idx_q} < 32'(PAGE_SLOTS);
  assign rd_idx    = AW'(idx_q);
  assign e         = ent_i[rd_idx];
  assign hot_full  = hot_count_q >= max_hot_q;
  assign span_end  = {1'b0, start_q} + 17'(PAGE_TOKENS);
  assign more      = span_end < {1'b0, tc_q};
  assign end_tok   = more ? span_end[15:0] : tc_q;
  assign out_free  = !out_valid_q || out_ready_i;
  assign scan_done = scan_cnt_q == CW'(PAGE_SLOTS);
  assign needs_hot = ((mode_q == MODE_ACCESS) &&
                      ((e.tier == TIER_FREE) || (e.tier == TIER_COLD))) ||
                     ((mode_q == MODE_PROMOTE) && (e.tier != TIER_HOT));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (mode_q == MODE_ALLOC) begin
          state_d = (tc_q == 16'd0) ? S_IDLE : S_SCAN;
        end else if (mode_q == MODE_CLEAR || !in_range || !e.valid) begin
          state_d = S_EMIT;
        end else if (needs_hot) begin
          state_d = hot_full ? S_SCAN : S_PROMO;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_SCAN: begin
        if (scan_done) state_d = (mode_q == MODE_ALLOC) ? S_EMIT : S_PROMO;
      end
      S_PROMO: state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) state_d = res_q.last ? S_IDLE : S_SCAN;
      end
    endcase
  end

  always_comb begin
    mode_d      = mode_q;
    idx_d       = idx_q;
    tc_d        = tc_q;
    start_d     = start_q;
    k_d         = k_q;
    scan_cnt_d  = scan_cnt_q;
    hot_count_d = hot_count_q;
    use_clock_d = use_clock_q;
    max_hot_d   = cfg_we_i ? cfg_wdata_i : max_hot_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    wr_idx_o    = rd_idx;
    in_ready_o  = state_q == S_IDLE;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_e'(mode_i);
          idx_d   = page_index_i;
          tc_d    = token_count_i;
          start_d = '0;
          k_d     = '0;
        end
      end
      S_EXEC: begin
        res_d         = '0;
        res_d.last    = 1'b1;
        scan_cnt_d    = '0;
        if (mode_q == MODE_ALLOC) begin
          res_d.last = 1'b0;
        end else if (mode_q == MODE_CLEAR) begin
          cmd_o.clr   = 1'b1;
          hot_count_d = '0;
          use_clock_d = '0;
        end else if (!in_range || !e.valid) begin
          res_d.page_id = idx_q;
          res_d.status  = ST_NO_PAGE;
        end else begin
          res_d.page_id = idx_q;
          res_d.tier    = e.tier;
          cmd_o.ent     = e;
          unique case (mode_q)
            MODE_FREE: begin
              cmd_o.wr  = 1'b1;
              cmd_o.ent = '{valid: 1'b0, tier: TIER_FREE, dirty: 1'b0, stamp: e.stamp};
              if (e.tier == TIER_HOT && hot_count_q != '0) hot_count_d = hot_count_q - 7'd1;
              res_d.tier = TIER_FREE;
            end
            MODE_ACCESS: begin
              if (e.tier == TIER_HOT || e.tier == TIER_WARM) begin
                res_d.hit       = 1'b1;
                cmd_o.wr        = 1'b1;
                cmd_o.ent.stamp = use_clock_q + 32'd1;
                use_clock_d     = use_clock_q + 32'd1;
              end else begin
                res_d.fault = 1'b1;
              end
            end
            MODE_WRITE: begin
              cmd_o.wr        = 1'b1;
              cmd_o.ent.dirty = 1'b1;
              cmd_o.ent.stamp = use_clock_q + 32'd1;
              use_clock_d     = use_clock_q + 32'd1;
            end
            MODE_WARM: begin
              cmd_o.wr       = 1'b1;
              cmd_o.ent.tier = TIER_WARM;
              if (e.tier == TIER_HOT && hot_count_q != '0) hot_count_d = hot_count_q - 7'd1;
              res_d.tier = TIER_WARM;
            end
            MODE_COLD: begin
              if (e.tier != TIER_COLD) begin
                res_d.save_request = e.dirty;
                cmd_o.wr           = 1'b1;
                cmd_o.ent.dirty    = 1'b0;
                cmd_o.ent.tier     = TIER_COLD;
                if (e.tier == TIER_HOT && hot_count_q != '0) begin
                  hot_count_d = hot_count_q - 7'd1;
                end
                res_d.tier = TIER_COLD;
              end
            end
            MODE_PROMOTE, MODE_ALLOC, MODE_CLEAR: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!scan_done) begin
          scan_cnt_d = scan_cnt_q + CW'(1);
        end else if (mode_q == MODE_ALLOC) begin
          res_d = '0;
          if (!tok_i.free_found || (k_q == 6'(MAX_RES - 1) && more)) begin
            res_d.status = ST_FULL;
            res_d.last   = 1'b1;
          end else begin
            cmd_o.wr          = 1'b1;
            wr_idx_o          = free_idx_i;
            cmd_o.ent         = '{valid: 1'b1, tier: TIER_FREE, dirty: 1'b0,
                                  stamp: use_clock_q + 32'd1};
            use_clock_d       = use_clock_q + 32'd1;
            res_d.page_id     = 6'(free_idx_i);
            res_d.span_lo     = start_q;
            res_d.span_hi     = end_tok;
            res_d.last        = !more;
            start_d           = span_end[15:0];
            k_d               = k_q + 6'd1;
          end
        end else if (tok_i.hot_found) begin
          cmd_o.wr            = 1'b1;
          wr_idx_o            = hot_idx_i;
          cmd_o.ent           = '{valid: 1'b1, tier: TIER_WARM, dirty: 1'b0,
                                  stamp: tok_i.hot_stamp};
          res_d.save_request  = tok_i.hot_dirty;
          res_d.evicted_valid = 1'b1;
          res_d.evicted_page  = 6'(hot_idx_i);
          if (hot_count_q != '0) hot_count_d = hot_count_q - 7'd1;
        end
      end
      S_PROMO: begin
        if (hot_full) begin
          res_d.status = ST_NO_HOT;
        end else begin
          cmd_o.wr       = 1'b1;
          cmd_o.ent      = e;
          cmd_o.ent.tier = TIER_HOT;
          hot_count_d    = hot_count_q + 7'd1;
          res_d.tier     = TIER_HOT;
          if (mode_q == MODE_ACCESS) begin
            cmd_o.ent.stamp    = use_clock_q + 32'd1;
            use_clock_d        = use_clock_q + 32'd1;
            res_d.load_request = e.tier == TIER_COLD;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          scan_cnt_d  = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_cnt_q  <= '0;
      hot_count_q <= '0;
      use_clock_q <= '0;
      max_hot_q   <= 7'(MAX_HOT_RST);
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      scan_cnt_q  <= scan_cnt_d;
      hot_count_q <= hot_count_d;
      use_clock_q <= use_clock_d;
      max_hot_q   <= max_hot_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    idx_q   <= idx_d;
    tc_q    <= tc_d;
    start_q <= start_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: sim/tiered_page_table_lru_tb.sv
module tiered_page_table_lru_tb;
  import tptl_pkg::*;

  localparam int NPG = 64;
  localparam int PTOK = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;

  tiered_page_table_lru u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .cfg_we_i, .cfg_wdata_i
  );

  always #4 clk_i = ~clk_i;

  // page table mirror
  logic        pv_valid [NPG];
  tier_e       pv_tier  [NPG];
  logic        pv_dirty [NPG];
  logic [31:0] pv_stamp [NPG];
  logic [6:0]  hot_cnt;
  logic [31:0] use_clk;
  logic [6:0]  hot_budget;

  res_t pending_res[$];
  int   mismatches = 0;
  int   send_idle = 0;
  int   recv_idle = 0;

  function automatic res_t blank_res();
    res_t r;
    r = '0;
    r.status = ST_OK;
    r.tier = TIER_FREE;
    return r;
  endfunction

  task automatic expect_res(res_t r);
    pending_res.insert(pending_res.size(), r);
  endtask

  task automatic table_reset();
    for (int i = 0; i < NPG; i++) begin
      pv_valid[i] = 1'b0;
      pv_tier[i] = TIER_FREE;
      pv_dirty[i] = 1'b0;
      pv_stamp[i] = '0;
    end
    hot_cnt = '0;
    use_clk = '0;
  endtask

  task automatic touch(int s);
    use_clk = use_clk + 32'd1;
    pv_stamp[s] = use_clk;
  endtask

  task automatic raise_to_hot(int s, inout res_t r, output bit ok);
    int best;
    bit found;
    best = 0;
    found = 0;
    ok = 1;
    if (pv_tier[s] == TIER_HOT) return;
    if (hot_cnt >= hot_budget) begin
      for (int i = 0; i < NPG; i++)
        if (pv_valid[i] && pv_tier[i] == TIER_HOT &&
            (!found || pv_stamp[i] < pv_stamp[best])) begin
          best = i;
          found = 1;
        end
      if (found) begin
        if (pv_dirty[best]) begin
          r.save_request = 1'b1;
          pv_dirty[best] = 1'b0;
        end
        pv_tier[best] = TIER_WARM;
        if (hot_cnt > 0) hot_cnt--;
        r.evicted_valid = 1'b1;
        r.evicted_page = best[5:0];
      end
      if (hot_cnt >= hot_budget) begin
        ok = 0;
        return;
      end
    end
    pv_tier[s] = TIER_HOT;
    hot_cnt++;
  endtask

  task automatic drop_hot(int s);
    if (pv_tier[s] == TIER_HOT && hot_cnt > 0) hot_cnt--;
  endtask

  task automatic predict_request(mode_e md, logic [5:0] pg, logic [15:0] tc);
    res_t r;
    int n, k, s, e;
    bit ok;
    tier_e t;
    r = blank_res();
    if (md == MODE_ALLOC) begin
      n = (int'(tc) + PTOK - 1) / PTOK;
      k = 0;
      for (int i = 0; i < n; i++) begin
        r = blank_res();
        s = NPG;
        for (int j = 0; j < NPG; j++)
          if (!pv_valid[j]) begin
            s = j;
            break;
          end
        if (s >= NPG || (k == MAX_RES - 1 && i + 1 < n)) begin
          r.status = ST_FULL;
          r.last = 1'b1;
          expect_res(r);
          return;
        end
        pv_valid[s] = 1'b1;
        pv_tier[s] = TIER_FREE;
        pv_dirty[s] = 1'b0;
        touch(s);
        e = (i + 1) * PTOK;
        if (e > int'(tc)) e = int'(tc);
        r.page_id = s[5:0];
        r.span_lo = 16'(i * PTOK);
        r.span_hi = 16'(e);
        r.last = (i + 1 == n);
        expect_res(r);
        k++;
      end
      return;
    end
    r.last = 1'b1;
    if (md == MODE_CLEAR) begin
      table_reset();
      expect_res(r);
      return;
    end
    r.page_id = pg;
    s = pg;
    if (!pv_valid[s]) begin
      r.status = ST_NO_PAGE;
      expect_res(r);
      return;
    end
    t = pv_tier[s];
    case (md)
      MODE_FREE: begin
        drop_hot(s);
        pv_valid[s] = 1'b0;
        pv_tier[s] = TIER_FREE;
        pv_dirty[s] = 1'b0;
      end
      MODE_ACCESS: begin
        ok = 1;
        if (t == TIER_HOT || t == TIER_WARM) r.hit = 1'b1;
        else begin
          r.fault = 1'b1;
          raise_to_hot(s, r, ok);
          if (!ok) r.status = ST_NO_HOT;
          else if (t == TIER_COLD) r.load_request = 1'b1;
        end
        if (ok) touch(s);
      end
      MODE_WRITE: begin
        pv_dirty[s] = 1'b1;
        touch(s);
      end
      MODE_PROMOTE: begin
        raise_to_hot(s, r, ok);
        if (!ok) r.status = ST_NO_HOT;
      end
      MODE_WARM: begin
        drop_hot(s);
        pv_tier[s] = TIER_WARM;
      end
      default: begin
        if (t != TIER_COLD) begin
          if (pv_dirty[s]) begin
            r.save_request = 1'b1;
            pv_dirty[s] = 1'b0;
          end
          drop_hot(s);
          pv_tier[s] = TIER_COLD;
        end
      end
    endcase
    r.tier = pv_valid[s] ? pv_tier[s] : TIER_FREE;
    expect_res(r);
  endtask

  task automatic send_request(mode_e md, logic [5:0] pg, logic [15:0] tc);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= md;
    s_axis_tdata <= {2'b00, tc, pg};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_request(md, pg, tc);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() > 0) @(negedge clk_i);
    repeat (NPG + 20) @(negedge clk_i);
  endtask

  task automatic set_budget(logic [6:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    hot_budget = v;
  endtask

  always @(negedge clk_i)
    m_axis_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);

  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '0;
      got.page_id = m_axis_tdata[5:0];
      got.status = status_e'(m_axis_tdata[7:6]);
      got.tier = tier_e'(m_axis_tdata[9:8]);
      got.span_lo = m_axis_tdata[25:10];
      got.span_hi = m_axis_tdata[41:26];
      got.hit = m_axis_tdata[42];
      got.fault = m_axis_tdata[43];
      got.load_request = m_axis_tdata[44];
      got.save_request = m_axis_tdata[45];
      got.evicted_valid = m_axis_tdata[46];
      got.evicted_page = m_axis_tdata[52:47];
      got.last = m_axis_tlast;
      if (pending_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %h", m_axis_tdata);
      end else begin
        want = pending_res.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  function automatic logic [5:0] live_page();
    for (int i = 0; i < 8; i++) begin
      logic [5:0] p;
      p = 6'($urandom_range(NPG - 1));
      if (pv_valid[p]) return p;
    end
    return 6'($urandom_range(NPG - 1));
  endfunction

  task automatic test_directed();
    send_request(MODE_FREE, 6'd0, 16'd0);
    send_request(MODE_ALLOC, 6'd0, 16'd0);
    send_request(MODE_ALLOC, 6'h3f, 16'd33);
    send_request(MODE_ACCESS, 6'd0, 16'hffff);
    send_request(MODE_WRITE, 6'd0, 16'd0);
    send_request(MODE_COLD, 6'd0, 16'd0);
    send_request(MODE_COLD, 6'd0, 16'd0);
    send_request(MODE_ACCESS, 6'd0, 16'd0);
    send_request(MODE_PROMOTE, 6'd0, 16'd0);
    send_request(MODE_PROMOTE, 6'd1, 16'd0);
    send_request(MODE_WARM, 6'd1, 16'd0);
    send_request(MODE_WARM, 6'd1, 16'd0);
    send_request(MODE_ACCESS, 6'd1, 16'd0);
    send_request(MODE_FREE, 6'd2, 16'd0);
    send_request(MODE_ACCESS, 6'd63, 16'd0);
    send_request(MODE_ALLOC, 6'd0, 16'hffff);
    send_request(MODE_ALLOC, 6'd0, 16'd1);
    send_request(MODE_CLEAR, 6'd0, 16'd0);
  endtask

  task automatic test_budget_edges();
    set_budget(7'd0);
    send_request(MODE_ALLOC, 6'd0, 16'd64);
    send_request(MODE_PROMOTE, 6'd0, 16'd0);
    send_request(MODE_ACCESS, 6'd1, 16'd0);
    set_budget(7'd1);
    send_request(MODE_WRITE, 6'd0, 16'd0);
    send_request(MODE_PROMOTE, 6'd0, 16'd0);
    send_request(MODE_ACCESS, 6'd1, 16'd0);
    send_request(MODE_PROMOTE, 6'd2, 16'd0);
    set_budget(7'd64);
    send_request(MODE_ALLOC, 6'd0, 16'd1000);
    for (int i = 0; i < 64; i++) send_request(MODE_PROMOTE, 6'(i), 16'd0);
    set_budget(7'd127);
    send_request(MODE_CLEAR, 6'd0, 16'd0);
  endtask

  task automatic test_random(int count);
    int r;
    mode_e md;
    logic [15:0] tc;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      tc = $urandom_range(4) == 0 ? 16'($urandom) : 16'($urandom_range(80));
      if (r < 8) md = MODE_ALLOC;
      else if (r < 16) md = MODE_FREE;
      else if (r < 45) md = MODE_ACCESS;
      else if (r < 58) md = MODE_WRITE;
      else if (r < 72) md = MODE_PROMOTE;
      else if (r < 84) md = MODE_WARM;
      else if (r < 98) md = MODE_COLD;
      else md = MODE_CLEAR;
      send_request(md, $urandom_range(9) == 0 ? 6'($urandom) : live_page(), tc);
      if (i == count / 2) drain();
    end
  endtask

  initial begin
    hot_budget = 7'd16;
    table_reset();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    send_idle = 10;
    recv_idle = 52;
    test_directed();
    test_budget_edges();
    set_budget(7'd4);
    test_random(105);
    send_idle = 52;
    recv_idle = 10;
    set_budget(7'd2);
    test_random(105);
    send_idle = 0;
    recv_idle = 0;
    set_budget(7'd16);
    test_random(105);
    drain();
    if (mismatches == 0 && pending_res.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #200000000;
    $display("status: fail");
    $finish;
  end

endmodule
